/* rtl/tesp_pkg.sv */
// ----------------------------------------------------------------------------
// tesp_pkg
// Shared types and constants of the terminal escape sequence parser.
// ----------------------------------------------------------------------------
package tesp_pkg;

  // Byte values the parser keys on
  localparam logic [7:0] ESC_BYTE      = 8'h1b;
  localparam logic [7:0] CSI_OPEN      = 8'h5b;  // '['
  localparam logic [7:0] SS3_OPEN      = 8'h4f;  // 'O'
  localparam logic [7:0] LAST_CTL      = 8'h1f;
  localparam logic [7:0] DEL_BYTE      = 8'h7f;
  localparam logic [7:0] INTER_LO      = 8'h20;
  localparam logic [7:0] INTER_HI      = 8'h2f;
  localparam logic [7:0] DIGIT_LO      = 8'h30;
  localparam logic [7:0] DIGIT_HI      = 8'h39;
  localparam logic [7:0] COLON_BYTE    = 8'h3a;
  localparam logic [7:0] SEMI_BYTE     = 8'h3b;
  localparam logic [7:0] PRIV_LO       = 8'h3c;
  localparam logic [7:0] PRIV_HI       = 8'h3f;
  localparam logic [7:0] FINAL_LO      = 8'h40;
  localparam logic [7:0] FINAL_HI      = 8'h7e;
  localparam logic [7:0] INTER_OFFSET  = 8'h1f;

  localparam logic [15:0] ACC_MAX      = 16'hffff;

  // Result kinds
  localparam logic [1:0] KIND_PLAIN    = 2'd0;
  localparam logic [1:0] KIND_PARAM    = 2'd1;
  localparam logic [1:0] KIND_SEQ      = 2'd2;

  // Entries of the command queue between parser and emitter
  localparam int unsigned QUEUE_DEPTH  = 4;

  typedef enum logic [1:0] {
    CMD_KEY,       // one plain key byte
    CMD_ESC_PAIR,  // escape byte, then the byte in code
    CMD_SEQ        // stored parameters, then the sequence code
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [12:0] code;
  } cmd_t;

endpackage

/* rtl/terminal_escape_sequence_parser_core.sv */
// ----------------------------------------------------------------------------
// terminal_escape_sequence_parser_core
// Splits a terminal byte stream into key codes and control sequence results.
// ----------------------------------------------------------------------------
// One byte is taken per clock while in_ready is high. A plain key passes
// through the command queue and then leaves through the output register. A
// byte after escape yields two results, the escape byte and then the byte
// itself. A final byte of a sequence with N parameters yields N+1 results:
// the emitter takes the command, reads each parameter through the registered
// port of the parameter store, then emits the sequence code. The parser runs
// ahead of the emitter through a four-entry command queue; it stalls when
// that queue is full, and in the parameter state while the parameters of the
// previous sequence are still being read from the store.
module terminal_escape_sequence_parser_core import tesp_pkg::*; #(
  parameter int unsigned MAX_PARAMS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  item_kind,
  output logic [12:0] key_code,
  output logic [15:0] param_value,
  output logic [3:0]  param_index,
  output logic [4:0]  param_total,
  output logic        last_of_run
);

  localparam int unsigned CNT_W  = $clog2(MAX_PARAMS + 1);
  localparam int unsigned ADDR_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int unsigned Q_W    = $bits(cmd_t) + CNT_W;

  logic              q_push, q_pop, q_full, q_empty;
  cmd_t              push_cmd, q_cmd;
  logic [CNT_W-1:0]  push_total, q_total;
  logic [Q_W-1:0]    q_rdata;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       wr_data;
  logic              seq_done;

  tesp_front #(.MAX_PARAMS(MAX_PARAMS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (data_byte),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .push_total (push_total),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .seq_done   (seq_done)
  );

  tesp_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({push_cmd, push_total}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign q_cmd   = q_rdata[Q_W-1:CNT_W];
  assign q_total = q_rdata[CNT_W-1:0];

  tesp_back #(.MAX_PARAMS(MAX_PARAMS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_cmd       (q_cmd),
    .q_total     (q_total),
    .pop         (q_pop),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .seq_done    (seq_done),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .item_kind   (item_kind),
    .key_code    (key_code),
    .param_value (param_value),
    .param_index (param_index),
    .param_total (param_total),
    .last_of_run (last_of_run)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command queue underflow");

  a_plain_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && item_kind == KIND_PLAIN) |->
      (param_total == 5'd0 && param_index == 4'd0 && param_value == 16'd0 &&
       key_code[12:8] == 5'd0))
    else $error("plain key carries sequence fields");

  a_param_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && item_kind == KIND_PARAM) |->
      (!last_of_run && param_total != 5'd0 && key_code[12]))
    else $error("parameter result malformed");

endmodule

/* rtl/tesp_queue.sv */
// ----------------------------------------------------------------------------
// tesp_queue
// Small register FIFO that carries parser commands to the emitter.
// ----------------------------------------------------------------------------
module tesp_queue import tesp_pkg::*; #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/tesp_front.sv */
// ----------------------------------------------------------------------------
// tesp_front
// Byte classifier and parse state machine. Collects parameters into the
// emitter's store and queues one command per byte that yields results.
// ----------------------------------------------------------------------------
module tesp_front import tesp_pkg::*; #(
  parameter int unsigned MAX_PARAMS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [7:0]                             data_byte,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   q_full,
  output logic                                   push,
  output cmd_t                                   push_cmd,
  output logic [$clog2(MAX_PARAMS + 1)-1:0]      push_total,
  output logic                                   wr_en,
  output logic [((MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1)-1:0] wr_addr,
  output logic [15:0]                            wr_data,
  input  logic                                   seq_done
);

  localparam int unsigned CNT_W  = $clog2(MAX_PARAMS + 1);
  localparam int unsigned ADDR_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

  typedef enum logic [1:0] {
    M_GROUND,
    M_ESCAPE,
    M_START,
    M_PARAMS
  } mode_t;

  mode_t            mode, mode_next;
  logic [6:0]       marker, marker_next;
  logic [15:0]      acc, acc_next;
  logic [CNT_W-1:0] count, count_next;
  logic             store_busy;

  logic             accept;
  logic             push_req;
  logic             wr_req;
  logic             is_ctl, is_inter, is_digit, is_sep, is_priv, is_final;
  logic [7:0]       priv_diff;
  logic [7:0]       inter_diff;
  logic [19:0]      acc_times_ten;
  logic [15:0]      acc_digit;
  logic             room;

  assign is_ctl   = (data_byte <= LAST_CTL && data_byte != ESC_BYTE) ||
                    (data_byte == DEL_BYTE);
  assign is_inter = (data_byte >= INTER_LO) && (data_byte <= INTER_HI);
  assign is_digit = (data_byte >= DIGIT_LO) && (data_byte <= DIGIT_HI);
  assign is_sep   = (data_byte == COLON_BYTE) || (data_byte == SEMI_BYTE);
  assign is_priv  = (data_byte >= PRIV_LO) && (data_byte <= PRIV_HI);
  assign is_final = (data_byte >= FINAL_LO) && (data_byte <= FINAL_HI);

  assign priv_diff  = data_byte - SEMI_BYTE;
  assign inter_diff = data_byte - INTER_OFFSET;

  // acc * 10 + digit, saturated to 16 bits
  assign acc_times_ten = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} +
                         {16'd0, data_byte[3:0]};
  assign acc_digit     = (acc_times_ten[19:16] != 4'd0) ? ACC_MAX : acc_times_ten[15:0];

  assign room = (count < CNT_W'(MAX_PARAMS));

  // Hold off input while the queue is full, and in the parameter state while the previous sequence is still read out
  assign in_ready = !q_full && !(store_busy && mode == M_PARAMS);
  assign accept   = in_valid && in_ready;
  assign push     = accept && push_req;
  assign wr_en    = accept && wr_req;
  assign wr_addr  = count[ADDR_W-1:0];
  assign wr_data  = acc;

  always_comb begin
    mode_next   = mode;
    marker_next = marker;
    acc_next    = acc;
    count_next  = count;
    push_req    = 1'b0;
    wr_req      = 1'b0;
    push_cmd    = '{kind: CMD_KEY, code: {5'd0, data_byte}};
    push_total  = '0;
    case (mode)
      M_GROUND: begin
        if (data_byte == ESC_BYTE) begin
          mode_next = M_ESCAPE;
        end else begin
          push_req = 1'b1;
        end
      end
      M_ESCAPE: begin
        if (data_byte == SS3_OPEN || data_byte == CSI_OPEN) begin
          count_next = '0;
          acc_next   = '0;
          mode_next  = M_START;
        end else begin
          push_req      = 1'b1;
          push_cmd.kind = CMD_ESC_PAIR;
          mode_next     = M_GROUND;
        end
      end
      M_START: begin
        if (data_byte == ESC_BYTE) begin
          mode_next = M_ESCAPE;
        end else if (is_ctl) begin
          mode_next = M_START;
        end else if (is_inter) begin
          marker_next = {3'd0, data_byte[3:0]};
          acc_next    = '0;
          mode_next   = M_PARAMS;
        end else if (is_digit) begin
          marker_next = '0;
          acc_next    = {12'd0, data_byte[3:0]};
          count_next  = '0;
          mode_next   = M_PARAMS;
        end else if (is_priv) begin
          marker_next = {priv_diff[2:0], 4'd0};
          count_next  = '0;
          mode_next   = M_PARAMS;
        end else if (is_final) begin
          // final byte minus 0x40 is its low six bits; no marker here
          count_next = '0;
          push_req   = 1'b1;
          push_cmd   = '{kind: CMD_SEQ, code: {7'b1000000, data_byte[5:0]}};
          mode_next  = M_GROUND;
        end else begin
          mode_next = M_GROUND;
        end
      end
      M_PARAMS: begin
        if (data_byte == ESC_BYTE) begin
          mode_next = M_ESCAPE;
        end else if (is_ctl) begin
          mode_next = M_PARAMS;
        end else if (is_inter) begin
          marker_next = marker | {2'd0, inter_diff[4:0]};
        end else if (is_digit) begin
          acc_next = acc_digit;
        end else if (is_sep) begin
          if (room) begin
            wr_req     = 1'b1;
            count_next = count + CNT_W'(1);
            acc_next   = '0;
          end
        end else if (is_final) begin
          // marker bit 6 lands on bit 12, which is set anyway
          if (room) begin
            wr_req     = 1'b1;
            count_next = count + CNT_W'(1);
            push_req   = 1'b1;
            push_cmd   = '{kind: CMD_SEQ, code: {1'b1, marker[5:0], data_byte[5:0]}};
            push_total = count + CNT_W'(1);
          end
          mode_next = M_GROUND;
        end else begin
          mode_next = M_GROUND;
        end
      end
      default: begin
        mode_next = M_GROUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_GROUND;
      marker     <= '0;
      acc        <= '0;
      count      <= '0;
      store_busy <= 1'b0;
    end else begin
      if (accept) begin
        mode   <= mode_next;
        marker <= marker_next;
        acc    <= acc_next;
        count  <= count_next;
      end
      if (push && push_cmd.kind == CMD_SEQ && push_total != '0) begin
        store_busy <= 1'b1;
      end else if (seq_done) begin
        store_busy <= 1'b0;
      end
    end
  end

endmodule

/* rtl/tesp_back.sv */
// ----------------------------------------------------------------------------
// tesp_back
// Emitter: pops parser commands, reads the parameter store and drives the
// registered result port.
// ----------------------------------------------------------------------------
module tesp_back import tesp_pkg::*; #(
  parameter int unsigned MAX_PARAMS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_empty,
  input  cmd_t                                   q_cmd,
  input  logic [$clog2(MAX_PARAMS + 1)-1:0]      q_total,
  output logic                                   pop,
  input  logic                                   wr_en,
  input  logic [((MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1)-1:0] wr_addr,
  input  logic [15:0]                            wr_data,
  output logic                                   seq_done,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [1:0]                             item_kind,
  output logic [12:0]                            key_code,
  output logic [15:0]                            param_value,
  output logic [3:0]                             param_index,
  output logic [4:0]                             param_total,
  output logic                                   last_of_run
);

  localparam int unsigned CNT_W  = $clog2(MAX_PARAMS + 1);
  localparam int unsigned ADDR_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ESC2,
    B_FETCH,
    B_PARAM,
    B_CODE
  } back_state_t;

  back_state_t      st;
  logic [12:0]      cur_code;
  logic [CNT_W-1:0] cur_total;
  logic [ADDR_W-1:0] idx;
  logic [15:0]      store [MAX_PARAMS];
  logic [15:0]      rd_data;
  logic             out_free;
  logic             out_load;
  logic             last_param;
  logic [31:0]      idx_wide;

  assign out_free   = !out_valid || out_ready;
  assign pop        = (st == B_IDLE) && !q_empty && out_free;
  assign seq_done   = (st == B_CODE) && out_free;
  assign last_param = (CNT_W'(idx) + CNT_W'(1)) == cur_total;
  assign idx_wide   = 32'(idx);

  // a new result enters the output register this cycle
  assign out_load = (pop && (q_cmd.kind == CMD_KEY || q_cmd.kind == CMD_ESC_PAIR ||
                             (q_cmd.kind == CMD_SEQ && q_total == '0))) ||
                    (out_free && (st == B_ESC2 || st == B_PARAM || st == B_CODE));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    rd_data <= store[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= B_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (st)
        B_IDLE: begin
          if (pop) begin
            cur_code  <= q_cmd.code;
            cur_total <= q_total;
            idx       <= '0;
            case (q_cmd.kind)
              CMD_KEY: begin
                item_kind   <= KIND_PLAIN;
                key_code    <= q_cmd.code;
                param_value <= '0;
                param_index <= '0;
                param_total <= '0;
                last_of_run <= 1'b1;
              end
              CMD_ESC_PAIR: begin
                item_kind   <= KIND_PLAIN;
                key_code    <= {5'd0, ESC_BYTE};
                param_value <= '0;
                param_index <= '0;
                param_total <= '0;
                last_of_run <= 1'b0;
                st          <= B_ESC2;
              end
              CMD_SEQ: begin
                if (q_total == '0) begin
                  item_kind   <= KIND_SEQ;
                  key_code    <= q_cmd.code;
                  param_value <= '0;
                  param_index <= '0;
                  param_total <= '0;
                  last_of_run <= 1'b1;
                end else begin
                  st <= B_FETCH;
                end
              end
              default: begin
                st <= B_IDLE;
              end
            endcase
          end
        end
        B_ESC2: begin
          if (out_free) begin
            item_kind   <= KIND_PLAIN;
            key_code    <= cur_code;
            last_of_run <= 1'b1;
            st          <= B_IDLE;
          end
        end
        B_FETCH: begin
          // store read for idx lands in rd_data at this edge
          st <= B_PARAM;
        end
        B_PARAM: begin
          if (out_free) begin
            item_kind   <= KIND_PARAM;
            key_code    <= cur_code;
            param_value <= rd_data;
            param_index <= idx_wide[3:0];
            param_total <= 5'(cur_total);
            last_of_run <= 1'b0;
            if (last_param) begin
              st <= B_CODE;
            end else begin
              idx <= idx + ADDR_W'(1);
              st  <= B_FETCH;
            end
          end
        end
        B_CODE: begin
          if (out_free) begin
            item_kind   <= KIND_SEQ;
            key_code    <= cur_code;
            param_value <= '0;
            param_index <= '0;
            param_total <= 5'(cur_total);
            last_of_run <= 1'b1;
            st          <= B_IDLE;
          end
        end
        default: begin
          st <= B_IDLE;
        end
      endcase
    end
  end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the terminal escape sequence parser core.
// ----------------------------------------------------------------------------
// A short directed byte stream hits plain bytes at both ends of the range and
// escape pairs. It also covers an SS3 final at sequence start, private
// and intermediate markers, saturating parameters and abandoned sequences.
// A random stream follows. It is mostly well-formed sequences with random
// parameters, some past a full parameter store, mixed with plain bytes, escape
// pairs and broken sequences. A local model of the parser predicts every
// result, and the monitor checks each result field by field. The driver and
// the monitor both idle at random. There is one calm stretch with no idling,
// and one long receiver hold-off that backs the block up onto its input.
// ----------------------------------------------------------------------------
module testbench;
  import tesp_pkg::*;

  localparam int unsigned PARAM_SLOTS  = 16;
  localparam int unsigned RANDOM_BYTES = 340;
  localparam int unsigned HOLD_AT      = 60;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CALM_FROM    = 180;
  localparam int unsigned CALM_TO      = 260;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam logic [12:0] SEQ_FLAG     = 13'h1000;

  typedef enum logic [1:0] {
    SCAN_GROUND,
    SCAN_ESCAPE,
    SCAN_START,
    SCAN_PARAMS
  } scan_mode_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] code;
    logic [15:0] value;
    logic [3:0]  index;
    logic [4:0]  total;
    logic        last;
  } key_result_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic [7:0]  data_byte = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  item_kind;
  logic [12:0] key_code;
  logic [15:0] param_value;
  logic [3:0]  param_index;
  logic [4:0]  param_total;
  logic        last_of_run;

  terminal_escape_sequence_parser_core #(
    .MAX_PARAMS(PARAM_SLOTS)
  ) u_dut (.*);

  // Parser model state
  scan_mode_t  scan_mode   = SCAN_GROUND;
  logic [6:0]  mark_bits   = '0;
  int unsigned digit_acc   = 0;
  int unsigned param_count = 0;
  logic [15:0] param_slots [PARAM_SLOTS];

  logic [7:0]  byte_backlog [$];
  key_result_t expected_keys [$];

  int unsigned bytes_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned seq_codes    = 0;
  int unsigned mismatches   = 0;
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;
  int unsigned quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic push_expected(input logic [1:0] kind, input logic [12:0] code,
                               input logic [15:0] value, input logic [3:0] index,
                               input logic [4:0] total);
    key_result_t r;
    r.kind  = kind;
    r.code  = code;
    r.value = value;
    r.index = index;
    r.total = total;
    r.last  = 1'b0;
    expected_keys.push_back(r);
  endtask

  task automatic decode_terminal_byte(input logic [7:0] c);
    int unsigned before_cnt;
    int unsigned v;
    logic [12:0] code;
    logic        ignored;
    key_result_t r;
    before_cnt = expected_keys.size();
    ignored = (c < ESC_BYTE) || (c > ESC_BYTE && c <= LAST_CTL) || (c == DEL_BYTE);
    case (scan_mode)
      SCAN_GROUND: begin
        if (c == ESC_BYTE) scan_mode = SCAN_ESCAPE;
        else push_expected(KIND_PLAIN, {5'd0, c}, '0, '0, '0);
      end
      SCAN_ESCAPE: begin
        if (c == SS3_OPEN || c == CSI_OPEN) begin
          param_count = 0;
          digit_acc   = 0;
          scan_mode   = SCAN_START;
        end else begin
          push_expected(KIND_PLAIN, {5'd0, ESC_BYTE}, '0, '0, '0);
          push_expected(KIND_PLAIN, {5'd0, c}, '0, '0, '0);
          scan_mode = SCAN_GROUND;
        end
      end
      SCAN_START: begin
        if (c == ESC_BYTE) begin
          scan_mode = SCAN_ESCAPE;
        end else if (ignored) begin
          // hold state
        end else if (c >= INTER_LO && c <= INTER_HI) begin
          mark_bits = 7'(c - INTER_LO);
          digit_acc = 0;
          scan_mode = SCAN_PARAMS;
        end else if (c >= DIGIT_LO && c <= DIGIT_HI) begin
          mark_bits   = '0;
          digit_acc   = c - DIGIT_LO;
          param_count = 0;
          scan_mode   = SCAN_PARAMS;
        end else if (c >= PRIV_LO && c <= PRIV_HI) begin
          mark_bits   = 7'((c - SEMI_BYTE) << 4);
          param_count = 0;
          scan_mode   = SCAN_PARAMS;
        end else if (c >= FINAL_LO && c <= FINAL_HI) begin
          // final right after the opener: no parameters, marker not applied
          param_count = 0;
          push_expected(KIND_SEQ, SEQ_FLAG | 13'(c - FINAL_LO), '0, '0, '0);
          scan_mode = SCAN_GROUND;
        end else begin
          scan_mode = SCAN_GROUND;
        end
      end
      default: begin
        if (c == ESC_BYTE) begin
          scan_mode = SCAN_ESCAPE;
        end else if (ignored) begin
          // hold state
        end else if (c >= INTER_LO && c <= INTER_HI) begin
          mark_bits = mark_bits | 7'(c - INTER_OFFSET);
        end else if (c >= DIGIT_LO && c <= DIGIT_HI) begin
          v = digit_acc * 10 + (c - DIGIT_LO);
          digit_acc = (v > ACC_MAX) ? ACC_MAX : v;
        end else if (c == COLON_BYTE || c == SEMI_BYTE) begin
          // a full store drops the separator and keeps the accumulator
          if (param_count < PARAM_SLOTS) begin
            param_slots[param_count] = 16'(digit_acc);
            param_count = param_count + 1;
            digit_acc   = 0;
          end
        end else if (c >= FINAL_LO && c <= FINAL_HI) begin
          if (param_count < PARAM_SLOTS) begin
            param_slots[param_count] = 16'(digit_acc);
            param_count = param_count + 1;
            code = SEQ_FLAG | 13'({mark_bits, 6'd0}) | 13'(c - FINAL_LO);
            for (int i = 0; i < param_count; i++)
              push_expected(KIND_PARAM, code, param_slots[i], 4'(i), 5'(param_count));
            push_expected(KIND_SEQ, code, '0, '0, 5'(param_count));
          end
          scan_mode = SCAN_GROUND;
        end else begin
          scan_mode = SCAN_GROUND;
        end
      end
    endcase
    if (expected_keys.size() > before_cnt) begin
      r = expected_keys.pop_back();
      r.last = 1'b1;
      expected_keys.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] result %0d: %s", $realtime, results_seen, what);
    mismatches = mismatches + 1;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Driver: present the next byte when the slot is free, idle at random
  always @(posedge clk) begin : drive_proc
    logic idle;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      idle = ($urandom_range(0, 99) < 38) && !(bytes_sent >= CALM_FROM && bytes_sent < CALM_TO);
      if (in_valid && in_ready) begin
        decode_terminal_byte(data_byte);
        bytes_sent <= bytes_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (byte_backlog.size() != 0 && !idle) begin
          data_byte <= byte_backlog.pop_front();
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each transaction against the oldest prediction
  always @(posedge clk) begin : watch_proc
    key_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_keys.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_keys.pop_front();
          check_field("item_kind", item_kind, want.kind);
          check_field("key_code", key_code, want.code);
          check_field("param_value", param_value, want.value);
          check_field("param_index", param_index, want.index);
          check_field("param_total", param_total, want.total);
          check_field("last_of_run", last_of_run, want.last);
        end
        if (item_kind == KIND_SEQ) seq_codes <= seq_codes + 1;
        results_seen <= results_seen + 1;
      end
      // hold off once for a long stretch so the block backs up
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && bytes_sent >= HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 38) ||
                     (bytes_sent >= CALM_FROM && bytes_sent < CALM_TO);
      end
    end
  end

  // Watchdog: stop when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] directed [27] = '{
      8'h00, 8'hff,                         // plain byte extremes
      ESC_BYTE, 8'h78,                      // escape pair
      ESC_BYTE, SS3_OPEN, 8'h41,            // final at sequence start
      ESC_BYTE, CSI_OPEN, PRIV_HI, 8'h35, 8'h68,
      ESC_BYTE, CSI_OPEN, 8'h07, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39,
      8'h21, DEL_BYTE, COLON_BYTE, 8'h71,   // saturate, intermediate, ignored DEL
      ESC_BYTE, CSI_OPEN, SEMI_BYTE         // separator at start abandons
    };
    int unsigned roll;
    int unsigned prefix;
    int unsigned nparams;
    int unsigned ndigits;
    int unsigned lo;

    foreach (directed[k]) byte_backlog.push_back(directed[k]);

    while (byte_backlog.size() < $size(directed) + RANDOM_BYTES) begin
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
        byte_backlog.push_back(8'($urandom_range(0, 255)));
      end else if (roll < 30) begin
        byte_backlog.push_back(ESC_BYTE);
        byte_backlog.push_back(8'($urandom_range(0, 255)));
      end else if (roll < 85) begin
        byte_backlog.push_back(ESC_BYTE);
        byte_backlog.push_back(($urandom_range(0, 3) == 0) ? SS3_OPEN : CSI_OPEN);
        prefix = $urandom_range(0, 7);
        if (prefix == 0) byte_backlog.push_back(PRIV_LO + 8'($urandom_range(0, 3)));
        else if (prefix == 1) byte_backlog.push_back(INTER_LO + 8'($urandom_range(0, 15)));
        nparams = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 4);
        for (int i = 0; i < nparams; i++) begin
          // the first parameter needs a digit to leave the start state
          lo = (i == 0 && prefix > 1) ? 1 : 0;
          ndigits = ($urandom_range(0, 15) == 0) ? 6 : $urandom_range(lo, 3);
          for (int j = 0; j < ndigits; j++)
            byte_backlog.push_back(DIGIT_LO + 8'($urandom_range(0, 9)));
          if (ndigits != 0 && $urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
              0: byte_backlog.push_back(INTER_LO + 8'($urandom_range(0, 15)));
              1: byte_backlog.push_back(8'($urandom_range(0, 26)));
              default: byte_backlog.push_back(DEL_BYTE);
            endcase
          end
          if (i != nparams - 1)
            byte_backlog.push_back($urandom_range(0, 1) ? COLON_BYTE : SEMI_BYTE);
        end
        byte_backlog.push_back(FINAL_LO + 8'($urandom_range(0, FINAL_HI - FINAL_LO)));
      end else begin
        byte_backlog.push_back(ESC_BYTE);
        byte_backlog.push_back(CSI_OPEN);
        ndigits = $urandom_range(0, 2);
        for (int j = 0; j < ndigits; j++)
          byte_backlog.push_back(DIGIT_LO + 8'($urandom_range(0, 9)));
        case ($urandom_range(0, 3))
          0: byte_backlog.push_back(8'h80 + 8'($urandom_range(0, 127)));
          1: byte_backlog.push_back(PRIV_LO + 8'($urandom_range(0, 3)));
          2: byte_backlog.push_back(ESC_BYTE);
          default: byte_backlog.push_back($urandom_range(0, 1) ? COLON_BYTE : SEMI_BYTE);
        endcase
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (byte_backlog.size() != 0 || in_valid) @(posedge clk);
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input bytes and %0d results, %0d of them sequence codes,",
             bytes_sent, results_seen, seq_codes);
    $display("with one long receiver hold-off and a calm stretch without idling");
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
rtl/tesp_pkg.sv
rtl/tesp_queue.sv
rtl/tesp_front.sv
rtl/tesp_back.sv
rtl/terminal_escape_sequence_parser_core.sv
verif/testbench.sv
